>>> src/cfanh_pkg.sv
// Package for the case-folded Adler-style name hash.
// Holds the queue entry type, the modulus and the modular add; no dependencies.
`default_nettype none
package cfanh_pkg;

  localparam int SUM_BITS    = 16;
  localparam int HASH_BITS   = 2 * SUM_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_BITS-1:0] MOD_PRIME  = 16'd65521;
  localparam logic [SUM_BITS-1:0] STAR_CODE  = 16'd42;
  localparam logic [SUM_BITS-1:0] UPPER_A    = 16'd65;
  localparam logic [SUM_BITS-1:0] UPPER_Z    = 16'd90;
  localparam logic [SUM_BITS-1:0] CASE_SHIFT = 16'd32;

  typedef struct packed {
    logic [SUM_BITS-1:0] code;     // folded character, already below MOD_PRIME
    logic                is_star;
    logic                no_char;
    logic                last_char;
  } item_t;

  // a and b both below MOD_PRIME
  function automatic logic [SUM_BITS-1:0] mod_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_PRIME}) begin
      s = s - {1'b0, MOD_PRIME};
    end
    return s[SUM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/case_folded_adler_name_hash.sv
// Top level of the case-folded Adler-style name hash.
// Instantiates cfanh_front, cfanh_queue and cfanh_back; uses cfanh_pkg.
//
// Takes one character per transaction and sustains one transaction per clock
// while in_stall is low. A transaction is written into a two-entry queue at
// acceptance; the back end updates the sums when it pops the transaction (one
// modular add for the low sum feeding one for the high sum), and a name-ending
// transaction leaves its hash in the output register at that same edge. A
// name-ending transaction waits in the queue while the output is stalled with a
// hash waiting. in_stall rises only when the queue is full, which happens when
// such a transaction sits at its head and another is queued behind it.
`default_nettype none
module case_folded_adler_name_hash #(
  parameter int CHAR_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [CHAR_BITS-1:0]             ch,
  input  wire logic                             no_char,
  input  wire logic                             last_char,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [cfanh_pkg::HASH_BITS-1:0]       hash
);

  cfanh_pkg::item_t in_item;
  cfanh_pkg::item_t q_item;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  assign in_stall = q_full;

  cfanh_front #(
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .ch        (ch),
    .no_char   (no_char),
    .last_char (last_char),
    .item      (in_item)
  );

  cfanh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_valid && !q_full),
    .wr_item  (in_item),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  cfanh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hash      (hash)
  );

endmodule
`default_nettype wire

>>> src/cfanh_front.sv
// Front end: folds the character to lower case, reduces it modulo the prime
// and flags a star. Uses cfanh_pkg.
`default_nettype none
module cfanh_front #(
  parameter int CHAR_BITS = 8
) (
  input  wire logic [CHAR_BITS-1:0] ch,
  input  wire logic                 no_char,
  input  wire logic                 last_char,
  output cfanh_pkg::item_t          item
);

  logic [cfanh_pkg::SUM_BITS-1:0] c_wide;
  logic [cfanh_pkg::SUM_BITS-1:0] c_code;

  assign c_wide = cfanh_pkg::SUM_BITS'(ch);

  always_comb begin
    priority if (c_wide >= cfanh_pkg::UPPER_A && c_wide <= cfanh_pkg::UPPER_Z) begin
      c_code = c_wide + cfanh_pkg::CASE_SHIFT;
    end else if (c_wide >= cfanh_pkg::MOD_PRIME) begin
      c_code = c_wide - cfanh_pkg::MOD_PRIME;
    end else begin
      c_code = c_wide;
    end
  end

  assign item.code      = c_code;
  assign item.is_star   = (c_wide == cfanh_pkg::STAR_CODE);
  assign item.no_char   = no_char;
  assign item.last_char = last_char;

endmodule
`default_nettype wire

>>> src/cfanh_queue.sv
// Short transaction queue between front and back end.
// Uses cfanh_pkg for the entry type and depth.
`default_nettype none
module cfanh_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire cfanh_pkg::item_t wr_item,
  output logic                  full,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output cfanh_pkg::item_t      rd_item
);

  cfanh_pkg::item_t                entries [cfanh_pkg::QUEUE_DEPTH];
  logic [cfanh_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [cfanh_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [cfanh_pkg::QCNT_BITS-1:0] count;
  logic [cfanh_pkg::QCNT_BITS-1:0] count_next;

  assign full     = (count == cfanh_pkg::QCNT_BITS'(cfanh_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !(rd_en && rd_valid)) begin
      count_next = count + 1'b1;
    end else if (!wr_en && rd_en && rd_valid) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == cfanh_pkg::QPTR_BITS'(cfanh_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (rd_en && rd_valid) begin
        rd_ptr <= (rd_ptr == cfanh_pkg::QPTR_BITS'(cfanh_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

>>> src/cfanh_back.sv
// Back end: running sums modulo the prime, name-end handling and the
// registered result stage. Uses cfanh_pkg.
`default_nettype none
module cfanh_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire cfanh_pkg::item_t                q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [cfanh_pkg::HASH_BITS-1:0]      hash
);

  logic [cfanh_pkg::SUM_BITS-1:0]  low_sum, low_sum_next;
  logic [cfanh_pkg::SUM_BITS-1:0]  high_sum, high_sum_next;
  logic                            at_name_start, at_name_start_next;
  logic                            only_star, only_star_next;
  logic [cfanh_pkg::SUM_BITS-1:0]  low_add;
  logic [cfanh_pkg::SUM_BITS-1:0]  high_add;
  logic                            star_now;
  logic                            emits;
  logic [cfanh_pkg::HASH_BITS-1:0] result;

  assign emits    = q_item.no_char || q_item.last_char;
  assign q_pop    = q_valid && (!emits || !out_valid || !out_stall);
  assign low_add  = cfanh_pkg::mod_add(low_sum, q_item.code);
  assign high_add = cfanh_pkg::mod_add(high_sum, low_add);
  assign star_now = at_name_start && q_item.is_star;

  always_comb begin
    low_sum_next       = low_sum;
    high_sum_next      = high_sum;
    at_name_start_next = at_name_start;
    only_star_next     = only_star;
    result             = '0;
    if (q_item.no_char) begin
      result             = only_star ? '0 : {high_sum, low_sum};
      low_sum_next       = '0;
      high_sum_next      = '0;
      at_name_start_next = 1'b1;
      only_star_next     = 1'b0;
    end else if (q_item.last_char) begin
      result             = star_now ? '0 : {high_add, low_add};
      low_sum_next       = '0;
      high_sum_next      = '0;
      at_name_start_next = 1'b1;
      only_star_next     = 1'b0;
    end else begin
      low_sum_next       = low_add;
      high_sum_next      = high_add;
      at_name_start_next = 1'b0;
      only_star_next     = star_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum       <= '0;
      high_sum      <= '0;
      at_name_start <= 1'b1;
      only_star     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        low_sum       <= low_sum_next;
        high_sum      <= high_sum_next;
        at_name_start <= at_name_start_next;
        only_star     <= only_star_next;
      end
      if (q_pop && emits) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emits) begin
      hash <= result;
    end
  end

endmodule
`default_nettype wire
